>>> hw/rtl/dsss_pkg.sv
// shared constants, types and the phase table of the dual stepper solenoid sequencer
package dsss_pkg;

  // conveyor step divisor, kept to a power of two so the modulo is a bit mask
  localparam int unsigned CONVEYOR_DIVISOR = 2;

  localparam int unsigned DivW      = 6;
  localparam int unsigned HoldW     = 7;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CoilW     = 4;
  localparam int unsigned SolW      = 6;
  localparam int unsigned CmdW      = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned OutDataW  = 16;

  localparam logic [DivW-1:0]   PeriodReset  = 6'd40;
  localparam logic [DivW-1:0]   ReleaseReset = 6'd4;
  localparam logic [HoldW-1:0]  HoldReset    = 7'd1;
  localparam logic [CountW-1:0] CountIdle    = 8'hFF;

  // input kinds carried in tuser
  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_COMMAND = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SORTER_PERIOD  = 2'd0,
    CFG_SORTER_RELEASE = 2'd1,
    CFG_SOLENOID_HOLD  = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

  // full-step phase pairs in step order, coil bits 3..0
  function automatic logic [CoilW-1:0] phase_pair(input logic [1:0] step);
    logic [CoilW-1:0] pair;
    case (step)
      2'd0:    pair = 4'b1001;
      2'd1:    pair = 4'b1010;
      2'd2:    pair = 4'b0110;
      2'd3:    pair = 4'b0101;
      default: pair = 4'b0000;
    endcase
    return pair;
  endfunction

endpackage

>>> hw/rtl/dual_stepper_solenoid_sequencer_core.sv
// top level of the dual stepper solenoid sequencer: input stage, step logic and drive line state
// each request on the slave stream is either a timer tick (tuser 0) or a solenoid command
// (tuser 1, code in tdata). a request is registered in an input stage and is applied, when the
// output is free, to the divider, phase counters, solenoid countdown and drive lines; those line
// registers are the result presented on the master stream, one result per request. the block
// takes one request per cycle unless the master stream stalls, passing the input register and
// the line registers; a stalled result holds the input stage, which still accepts one more
// request. the three config registers (sorter period, sorter release tick, solenoid hold) are
// written through the cfg channel, always ready; writes to an index past the list are dropped.
module dual_stepper_solenoid_sequencer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dsss_pkg::CmdW-1:0]           s_axis_tdata,  // [7:0] command_code
  input  logic                                s_axis_tuser,  // [0] operation
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dsss_pkg::OutDataW-1:0]       m_axis_tdata,  // [3:0] conveyor_coils,
                                                             // [7:4] sorter_coils,
                                                             // [13:8] solenoid_lines
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dsss_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [dsss_pkg::CfgDataW-1:0]       cfg_data_i
);

  // config registers
  logic [dsss_pkg::DivW-1:0]   period_q, period_d;
  logic [dsss_pkg::DivW-1:0]   release_q, release_d;
  logic [dsss_pkg::HoldW-1:0]  hold_q, hold_d;

  // input stage
  logic                        in_valid_q, in_valid_d;
  dsss_pkg::op_e               in_op_q, in_op_d;
  logic [dsss_pkg::CmdW-1:0]   in_code_q, in_code_d;

  // sequencer state, the line registers double as the result register
  logic                        out_valid_q, out_valid_d;
  logic [dsss_pkg::DivW-1:0]   tick_div_q, tick_div_d;
  logic [1:0]                  conv_step_q, conv_step_d;
  logic [1:0]                  sort_step_q, sort_step_d;
  logic [dsss_pkg::CountW-1:0] countdown_q, countdown_d;
  logic [dsss_pkg::CoilW-1:0]  conv_lines_q, conv_lines_d;
  logic [dsss_pkg::CoilW-1:0]  sort_lines_q, sort_lines_d;
  logic [dsss_pkg::SolW-1:0]   sol_bits_q, sol_bits_d;

  logic                        out_free;
  logic                        step_fire;
  logic                        in_fire;
  logic                        conv_hit;
  logic [2:0]                  sol_sel;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_fire     = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, sol_bits_q, sort_lines_q, conv_lines_q};

  // divisor is a power of two, so the modulo reduces to the low bits
  assign conv_hit = ((tick_div_q % dsss_pkg::DivW'(dsss_pkg::CONVEYOR_DIVISOR)) == '0);
  assign sol_sel  = in_code_q[2:0] - 3'd1;

  // config writes
  always_comb begin
    period_d  = period_q;
    release_d = release_q;
    hold_d    = hold_q;
    if (cfg_valid_i) begin
      case (dsss_pkg::cfg_idx_e'(cfg_index_i))
        dsss_pkg::CFG_SORTER_PERIOD:  period_d  = cfg_data_i[dsss_pkg::DivW-1:0];
        dsss_pkg::CFG_SORTER_RELEASE: release_d = cfg_data_i[dsss_pkg::DivW-1:0];
        dsss_pkg::CFG_SOLENOID_HOLD:  hold_d    = cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage
  always_comb begin
    in_valid_d = in_valid_q;
    in_op_d    = in_op_q;
    in_code_d  = in_code_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
      in_op_d    = dsss_pkg::op_e'(s_axis_tuser);
      in_code_d  = s_axis_tdata;
    end else if (step_fire) begin
      in_valid_d = 1'b0;
    end
  end

  // step logic
  always_comb begin
    out_valid_d  = out_valid_q;
    tick_div_d   = tick_div_q;
    conv_step_d  = conv_step_q;
    sort_step_d  = sort_step_q;
    countdown_d  = countdown_q;
    conv_lines_d = conv_lines_q;
    sort_lines_d = sort_lines_q;
    sol_bits_d   = sol_bits_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (step_fire) begin
      out_valid_d = 1'b1;
      case (in_op_q)
        dsss_pkg::OP_TICK: begin
          // conveyor steps on every divisor multiple, clears otherwise
          if (conv_hit) begin
            conv_lines_d = conv_lines_q | dsss_pkg::phase_pair(conv_step_q);
            conv_step_d  = conv_step_q + 2'd1;
          end else begin
            conv_lines_d = '0;
          end
          if (tick_div_q == period_q) begin
            // period wins over release when both match
            if (countdown_q == '0) begin
              countdown_d = dsss_pkg::CountIdle;
              sol_bits_d  = '0;
            end else if (!countdown_q[dsss_pkg::CountW-1]) begin
              countdown_d = countdown_q - 8'd1;
            end
            sort_lines_d = sort_lines_q | dsss_pkg::phase_pair(sort_step_q);
            sort_step_d  = sort_step_q + 2'd1;
            tick_div_d   = '0;
          end else begin
            if (tick_div_q == release_q) begin
              sort_lines_d = '0;
            end
            tick_div_d = tick_div_q + 6'd1;
          end
        end
        dsss_pkg::OP_COMMAND: begin
          if (in_code_q inside {[8'd1:8'd6]}) begin
            sol_bits_d = sol_bits_q | (dsss_pkg::SolW'(1) << sol_sel);
          end
          countdown_d = {1'b0, hold_q};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= dsss_pkg::PeriodReset;
      release_q    <= dsss_pkg::ReleaseReset;
      hold_q       <= dsss_pkg::HoldReset;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      tick_div_q   <= '0;
      conv_step_q  <= '0;
      sort_step_q  <= '0;
      countdown_q  <= dsss_pkg::CountIdle;
      conv_lines_q <= '0;
      sort_lines_q <= '0;
      sol_bits_q   <= '0;
    end else begin
      period_q     <= period_d;
      release_q    <= release_d;
      hold_q       <= hold_d;
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
      tick_div_q   <= tick_div_d;
      conv_step_q  <= conv_step_d;
      sort_step_q  <= sort_step_d;
      countdown_q  <= countdown_d;
      conv_lines_q <= conv_lines_d;
      sort_lines_q <= sort_lines_d;
      sol_bits_q   <= sol_bits_d;
    end
  end

  // input payload needs no reset
  always_ff @(posedge clk_i) begin
    in_op_q   <= in_op_d;
    in_code_q <= in_code_d;
  end

`ifndef SYNTHESIS
  // a negative countdown only ever holds the idle code
  a_countdown_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    countdown_q[dsss_pkg::CountW-1] |-> (countdown_q == dsss_pkg::CountIdle))
    else $error("countdown negative but not idle");

  // idle countdown means all solenoid lines are off
  a_idle_lines_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    countdown_q[dsss_pkg::CountW-1] |-> (sol_bits_q == '0))
    else $error("solenoid line on while countdown idle");

  // input side stalls only with a full input stage behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

  // a tick off a divisor multiple clears the conveyor lines
  a_conv_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && (in_op_q == dsss_pkg::OP_TICK) && !conv_hit) |=> (conv_lines_q == '0))
    else $error("conveyor lines not cleared");
`endif

endmodule
